[sv/isc_pkg.sv]
// ---------------------------------------------------------------------------
// Interval set coalescer package
// Shared widths, result codes, cell commands and cell status for the
// interval set coalescer.
// ---------------------------------------------------------------------------
package isc_pkg;

    localparam int FIELD_W                = 16;
    localparam int KIND_W                 = 3;
    localparam int DEFAULT_TABLE_ENTRIES  = 32;
    localparam int DEFAULT_VALUE_BITS     = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADDED     = 3'd0,
        KIND_DUPLICATE = 3'd1,
        KIND_FULL      = 3'd2,
        KIND_ENTRY     = 3'd3,
        KIND_EMPTY     = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ACT_HOLD      = 3'd0,
        ACT_MERGE     = 3'd1,
        ACT_EXT_LEFT  = 3'd2,
        ACT_EXT_RIGHT = 3'd3,
        ACT_INSERT    = 3'd4,
        ACT_ROTATE    = 3'd5
    } t_act;

    typedef struct packed {
        logic le;
        logic dup;
        logic join_left;
        logic join_right;
    } t_cell_flags;

endpackage

[sv/interval_set_coalescer_unit.sv]
// ---------------------------------------------------------------------------
// Interval set coalescer
// Sorted table of disjoint closed intervals kept in a row of cells; values
// are merged in on add and the table is streamed out on list.
// ---------------------------------------------------------------------------
// An add is taken in the accept cycle; in the S_ADD state that follows, every
// cell compares its interval with the value and the row merges, extends,
// inserts or holds; its single result beat is registered and shows in the
// cycle after. A list of a table holding N intervals gives, from S_LIST,
// one beat per interval, as the row rotates its contents past cell zero; a list
// of an empty table gives one beat and leaves the block idle at once. Result
// beats cannot be held off, so o_strobe marks each beat for one cycle only.
module interval_set_coalescer_unit #(
    parameter int TABLE_ENTRIES = isc_pkg::DEFAULT_TABLE_ENTRIES,
    parameter int VALUE_BITS    = isc_pkg::DEFAULT_VALUE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_op,
    input  logic [isc_pkg::FIELD_W-1:0]   i_value,
    output logic                          o_strobe,
    output logic [isc_pkg::KIND_W-1:0]    o_kind,
    output logic [isc_pkg::FIELD_W-1:0]   o_range_start,
    output logic [isc_pkg::FIELD_W-1:0]   o_range_end,
    output logic                          o_last
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int FW    = isc_pkg::FIELD_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ADD  = 3'b010,
        S_LIST = 3'b100
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [CNT_W-1:0]      r_idx;
    logic [CNT_W-1:0]      n_idx;
    logic [VALUE_BITS-1:0] r_value;
    logic                  r_strobe;
    logic                  n_strobe;
    isc_pkg::t_kind        r_kind;
    isc_pkg::t_kind        n_kind;
    logic [FW-1:0]         r_rstart;
    logic [FW-1:0]         n_rstart;
    logic [FW-1:0]         r_rend;
    logic [FW-1:0]         n_rend;
    logic                  r_last;
    logic                  n_last;

    isc_pkg::t_act         w_act;
    logic                  w_accept;
    logic [VALUE_BITS+FW-1:0] w_in_ext;
    logic [VALUE_BITS+FW-1:0] w_head_start_ext;
    logic [VALUE_BITS+FW-1:0] w_head_end_ext;

    isc_pkg::t_cell_flags  w_flags [TABLE_ENTRIES];
    logic [VALUE_BITS-1:0] w_start [TABLE_ENTRIES];
    logic [VALUE_BITS-1:0] w_end   [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] w_dup_vec;
    logic [TABLE_ENTRIES-1:0] w_jl_vec;
    logic [TABLE_ENTRIES-1:0] w_jr_vec;
    logic                  w_dup;
    logic                  w_jl;
    logic                  w_jr;
    logic                  w_full;
    logic                  w_list_last;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_in_ext = {{VALUE_BITS{1'b0}}, i_value};

    generate
        for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
            logic                  w_le_prev;
            logic                  w_le_next;
            logic [VALUE_BITS-1:0] w_ls;
            logic [VALUE_BITS-1:0] w_lend;
            logic [VALUE_BITS-1:0] w_rs;
            logic [VALUE_BITS-1:0] w_rend_n;

            if (k == 0) begin : g_first
                assign w_le_prev = 1'b1;
                assign w_ls      = '0;
                assign w_lend    = '0;
            end else begin : g_mid_l
                assign w_le_prev = w_flags[k-1].le;
                assign w_ls      = w_start[k-1];
                assign w_lend    = w_end[k-1];
            end

            if (k == TABLE_ENTRIES - 1) begin : g_last
                assign w_le_next = 1'b0;
                assign w_rs      = '0;
                assign w_rend_n  = '0;
            end else begin : g_mid_r
                assign w_le_next = w_flags[k+1].le;
                assign w_rs      = w_start[k+1];
                assign w_rend_n  = w_end[k+1];
            end

            isc_cell #(
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_act         (w_act),
                .i_value       (r_value),
                .i_valid       (CNT_W'(k) < r_count),
                .i_tail        (r_count == CNT_W'(k + 1)),
                .i_le_prev     (w_le_prev),
                .i_le_next     (w_le_next),
                .i_left_start  (w_ls),
                .i_left_end    (w_lend),
                .i_right_start (w_rs),
                .i_right_end   (w_rend_n),
                .i_head_start  (w_start[0]),
                .i_head_end    (w_end[0]),
                .o_flags       (w_flags[k]),
                .o_start       (w_start[k]),
                .o_end         (w_end[k])
            );

            assign w_dup_vec[k] = w_flags[k].dup;
            assign w_jl_vec[k]  = w_flags[k].join_left;
            assign w_jr_vec[k]  = w_flags[k].join_right;
        end
    endgenerate

    assign w_dup       = |w_dup_vec;
    assign w_jl        = |w_jl_vec;
    assign w_jr        = |w_jr_vec;
    assign w_full      = (r_count == CNT_W'(TABLE_ENTRIES));
    assign w_list_last = (r_idx == (r_count - CNT_W'(1)));

    assign w_head_start_ext = {{FW{1'b0}}, w_start[0]};
    assign w_head_end_ext   = {{FW{1'b0}}, w_end[0]};

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_strobe = 1'b0;
        n_kind   = r_kind;
        n_rstart = r_rstart;
        n_rend   = r_rend;
        n_last   = r_last;
        w_act    = isc_pkg::ACT_HOLD;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (!i_op) begin
                        n_state = S_ADD;
                    end else if (r_count == '0) begin
                        n_strobe = 1'b1;
                        n_kind   = isc_pkg::KIND_EMPTY;
                        n_rstart = '0;
                        n_rend   = '0;
                        n_last   = 1'b1;
                    end else begin
                        n_state = S_LIST;
                        n_idx   = '0;
                    end
                end
            end
            S_ADD: begin
                n_state  = S_IDLE;
                n_strobe = 1'b1;
                n_rstart = '0;
                n_rend   = '0;
                n_last   = 1'b1;
                n_kind   = isc_pkg::KIND_ADDED;
                priority if (w_dup) begin
                    n_kind = isc_pkg::KIND_DUPLICATE;
                end else if (w_jl && w_jr) begin
                    w_act   = isc_pkg::ACT_MERGE;
                    n_count = r_count - CNT_W'(1);
                end else if (w_jl) begin
                    w_act = isc_pkg::ACT_EXT_LEFT;
                end else if (w_jr) begin
                    w_act = isc_pkg::ACT_EXT_RIGHT;
                end else if (w_full) begin
                    n_kind = isc_pkg::KIND_FULL;
                end else begin
                    w_act   = isc_pkg::ACT_INSERT;
                    n_count = r_count + CNT_W'(1);
                end
            end
            S_LIST: begin
                w_act    = isc_pkg::ACT_ROTATE;
                n_strobe = 1'b1;
                n_kind   = isc_pkg::KIND_ENTRY;
                n_rstart = w_head_start_ext[FW-1:0];
                n_rend   = w_head_end_ext[FW-1:0];
                n_last   = w_list_last;
                n_idx    = r_idx + CNT_W'(1);
                if (w_list_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_value <= w_in_ext[VALUE_BITS-1:0];
        end
        r_idx    <= n_idx;
        r_kind   <= n_kind;
        r_rstart <= n_rstart;
        r_rend   <= n_rend;
        r_last   <= n_last;
    end

    assign o_strobe      = r_strobe;
    assign o_kind        = r_kind;
    assign o_range_start = r_rstart;
    assign o_range_end   = r_rend;
    assign o_last        = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_ENTRIES))
        else $error("Interval count exceeds the table size.");

    a_add_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) |=> (o_strobe && o_last))
        else $error("Add did not produce a single final beat.");

    a_list_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |=> (o_strobe && (o_kind == isc_pkg::KIND_ENTRY)))
        else $error("List cycle did not produce an entry beat.");

    a_one_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) |-> ($onehot0(w_jl_vec) && $onehot0(w_jr_vec)))
        else $error("More than one cell claims a neighbor join.");

endmodule

[sv/isc_cell.sv]
// ---------------------------------------------------------------------------
// Interval set coalescer cell
// Holds one interval of the sorted table, compares it against the incoming
// value and moves data to or from its neighbors on command.
// ---------------------------------------------------------------------------
module isc_cell #(
    parameter int VALUE_BITS = isc_pkg::DEFAULT_VALUE_BITS
) (
    input  logic                   i_clk,
    input  isc_pkg::t_act          i_act,
    input  logic [VALUE_BITS-1:0]  i_value,
    input  logic                   i_valid,
    input  logic                   i_tail,
    input  logic                   i_le_prev,
    input  logic                   i_le_next,
    input  logic [VALUE_BITS-1:0]  i_left_start,
    input  logic [VALUE_BITS-1:0]  i_left_end,
    input  logic [VALUE_BITS-1:0]  i_right_start,
    input  logic [VALUE_BITS-1:0]  i_right_end,
    input  logic [VALUE_BITS-1:0]  i_head_start,
    input  logic [VALUE_BITS-1:0]  i_head_end,
    output isc_pkg::t_cell_flags   o_flags,
    output logic [VALUE_BITS-1:0]  o_start,
    output logic [VALUE_BITS-1:0]  o_end
);

    logic [VALUE_BITS-1:0] r_start;
    logic [VALUE_BITS-1:0] r_end;
    logic [VALUE_BITS-1:0] n_start;
    logic [VALUE_BITS-1:0] n_end;
    logic                  w_le;
    logic                  w_is_left;
    logic                  w_is_right;
    logic                  w_at_slot;
    logic                  w_value_max;
    logic                  w_dup;
    logic                  w_join_left;
    logic                  w_join_right;

    assign w_le        = i_valid && (r_start <= i_value);
    assign w_is_left   = w_le && !i_le_next;
    assign w_is_right  = i_valid && !w_le && i_le_prev;
    assign w_at_slot   = !w_le && i_le_prev;
    assign w_value_max = (i_value == {VALUE_BITS{1'b1}});

    assign w_dup        = w_is_left && (r_end >= i_value);
    assign w_join_left  = w_is_left &&
                          (({1'b0, r_end} + (VALUE_BITS+1)'(1)) == {1'b0, i_value});
    assign w_join_right = w_is_right && !w_value_max &&
                          (r_start == (i_value + VALUE_BITS'(1)));

    assign o_flags = '{le: w_le, dup: w_dup, join_left: w_join_left,
                       join_right: w_join_right};

    always_comb begin
        n_start = r_start;
        n_end   = r_end;
        unique case (i_act)
            isc_pkg::ACT_MERGE: begin
                if (w_is_left) begin
                    n_end = i_right_end;
                end else if (!w_le) begin
                    n_start = i_right_start;
                    n_end   = i_right_end;
                end
            end
            isc_pkg::ACT_EXT_LEFT: begin
                if (w_is_left) begin
                    n_end = i_value;
                end
            end
            isc_pkg::ACT_EXT_RIGHT: begin
                if (w_is_right) begin
                    n_start = i_value;
                end
            end
            isc_pkg::ACT_INSERT: begin
                if (w_at_slot) begin
                    n_start = i_value;
                    n_end   = i_value;
                end else if (!i_le_prev) begin
                    n_start = i_left_start;
                    n_end   = i_left_end;
                end
            end
            isc_pkg::ACT_ROTATE: begin
                if (i_tail) begin
                    n_start = i_head_start;
                    n_end   = i_head_end;
                end else begin
                    n_start = i_right_start;
                    n_end   = i_right_end;
                end
            end
            default: begin
                n_start = r_start;
                n_end   = r_end;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_end   <= n_end;
    end

    assign o_start = r_start;
    assign o_end   = r_end;

endmodule

[tb/interval_set_coalescer_unit_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Interval set coalescer testbench
// A directed table followed by three random phases is sent to the coalescer.
// The directed rows cover the empty list, both ends of the value range,
// duplicates, joins on either side and the merge of two neighbors. The random
// phases fill the table past its capacity and keep merging values in a small
// window. An interval table kept alongside the block predicts every result
// beat, and each beat is checked field by field in order of arrival.
// ---------------------------------------------------------------------------
module interval_set_coalescer_unit_test;

    localparam int         TABLE_DEPTH = isc_pkg::DEFAULT_TABLE_ENTRIES;
    localparam logic       OP_ADD      = 1'b0;
    localparam logic       OP_LIST     = 1'b1;
    localparam int         DIR_ROWS    = 20;
    localparam int         RAND_ITEMS  = 110;
    localparam logic [15:0] TOP_VALUE  = 16'hFFFF;

    typedef struct packed {
        isc_pkg::t_kind kind;
        logic [15:0]    lo;
        logic [15:0]    hi;
        logic           last;
    } t_iv_beat;

    typedef struct {
        logic           op;
        logic [15:0]    value;
        bit             pinned;
        isc_pkg::t_kind kind;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_op = 1'b0;
    logic [15:0] i_value = 16'h0000;
    logic        o_strobe;
    logic [2:0]  o_kind;
    logic [15:0] o_range_start;
    logic [15:0] o_range_end;
    logic        o_last;

    logic           pin_valid = 1'b0;
    isc_pkg::t_kind pin_kind = isc_pkg::KIND_ADDED;

    logic [15:0] iv_lo [TABLE_DEPTH];
    logic [15:0] iv_hi [TABLE_DEPTH];
    int          iv_count = 0;

    t_iv_beat    pending_beats [$];
    t_iv_beat    head;
    t_dir_row    dir_rows [DIR_ROWS];
    int          errors = 0;
    int          beats_checked = 0;
    int          adds_sent = 0;
    int          lists_sent = 0;
    int          kind_count [5] = '{default: 0};

    interval_set_coalescer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_value       (i_value),
        .o_strobe      (o_strobe),
        .o_kind        (o_kind),
        .o_range_start (o_range_start),
        .o_range_end   (o_range_end),
        .o_last        (o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic isc_pkg::t_kind absorb_value(input logic [15:0] v);
        int pos;
        bit join_lo;
        bit join_hi;
        pos = 0;
        while (pos < iv_count && iv_lo[pos] <= v) pos++;
        if (pos > 0 && iv_hi[pos-1] >= v) return isc_pkg::KIND_DUPLICATE;
        join_lo = (pos > 0) && (int'(iv_hi[pos-1]) + 1 == int'(v));
        join_hi = (pos < iv_count) && (v != TOP_VALUE) && (int'(iv_lo[pos]) == int'(v) + 1);
        if (join_lo && join_hi) begin
            iv_hi[pos-1] = iv_hi[pos];
            for (int j = pos; j + 1 < iv_count; j++) begin
                iv_lo[j] = iv_lo[j+1];
                iv_hi[j] = iv_hi[j+1];
            end
            iv_count--;
        end else if (join_lo) begin
            iv_hi[pos-1] = v;
        end else if (join_hi) begin
            iv_lo[pos] = v;
        end else if (iv_count >= TABLE_DEPTH) begin
            return isc_pkg::KIND_FULL;
        end else begin
            for (int j = iv_count; j > pos; j--) begin
                iv_lo[j] = iv_lo[j-1];
                iv_hi[j] = iv_hi[j-1];
            end
            iv_lo[pos] = v;
            iv_hi[pos] = v;
            iv_count++;
        end
        return isc_pkg::KIND_ADDED;
    endfunction

    task automatic queue_beat(input isc_pkg::t_kind k, input logic [15:0] lo,
                              input logic [15:0] hi, input logic last);
        t_iv_beat b;
        b.kind = k;
        b.lo   = lo;
        b.hi   = hi;
        b.last = last;
        pending_beats.insert(pending_beats.size(), b);
    endtask

    task automatic predict_item(input logic op, input logic [15:0] v);
        isc_pkg::t_kind k;
        if (op == OP_ADD) begin
            k = absorb_value(v);
            queue_beat(k, 16'h0000, 16'h0000, 1'b1);
            kind_count[int'(k)]++;
        end else if (iv_count == 0) begin
            queue_beat(isc_pkg::KIND_EMPTY, 16'h0000, 16'h0000, 1'b1);
            kind_count[int'(isc_pkg::KIND_EMPTY)]++;
        end else begin
            for (int j = 0; j < iv_count; j++) begin
                queue_beat(isc_pkg::KIND_ENTRY, iv_lo[j], iv_hi[j], j + 1 == iv_count);
            end
            kind_count[int'(isc_pkg::KIND_ENTRY)] += iv_count;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                beats_checked++;
                if (pending_beats.size() == 0) begin
                    $error("unexpected result beat: kind %0d start %0h end %0h last %0b",
                           o_kind, o_range_start, o_range_end, o_last);
                    errors++;
                end else begin
                    head = pending_beats.pop_front();
                    if (o_kind !== head.kind) begin
                        $error("kind: expected %0d, actual %0d", head.kind, o_kind);
                        errors++;
                    end
                    if (o_range_start !== head.lo) begin
                        $error("range_start: expected %0h, actual %0h", head.lo, o_range_start);
                        errors++;
                    end
                    if (o_range_end !== head.hi) begin
                        $error("range_end: expected %0h, actual %0h", head.hi, o_range_end);
                        errors++;
                    end
                    if (o_last !== head.last) begin
                        $error("last: expected %0b, actual %0b", head.last, o_last);
                        errors++;
                    end
                end
            end
            if (start && !busy) begin
                predict_item(i_op, i_value);
                if (pin_valid) begin
                    pending_beats[pending_beats.size() - 1].kind = pin_kind;
                    pending_beats[pending_beats.size() - 1].lo   = 16'h0000;
                    pending_beats[pending_beats.size() - 1].hi   = 16'h0000;
                    pending_beats[pending_beats.size() - 1].last = 1'b1;
                end
            end
        end
    end

    task automatic send_item(input logic op, input logic [15:0] v, input bit pinned,
                             input isc_pkg::t_kind pkind);
        start     <= 1'b1;
        i_op      <= op;
        i_value   <= v;
        pin_valid <= pinned;
        pin_kind  <= pkind;
        do @(posedge i_clk); while (busy);
        if (op == OP_ADD) adds_sent++;
        else lists_sent++;
    endtask

    task automatic idle_some(input int pct);
        while ($urandom_range(0, 99) < pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    initial begin
        int          pct;
        int          r;
        logic        op;
        logic [15:0] v;

        dir_rows = '{
            '{OP_LIST, 16'h0000, 1'b1, isc_pkg::KIND_EMPTY},
            '{OP_ADD,  16'h0000, 1'b1, isc_pkg::KIND_ADDED},
            '{OP_ADD,  16'h0000, 1'b1, isc_pkg::KIND_DUPLICATE},
            '{OP_ADD,  16'hFFFF, 1'b1, isc_pkg::KIND_ADDED},
            '{OP_ADD,  16'hFFFE, 1'b0, isc_pkg::KIND_ADDED},
            '{OP_ADD,  16'h0001, 1'b0, isc_pkg::KIND_ADDED},
            '{OP_ADD,  16'h0003, 1'b0, isc_pkg::KIND_ADDED},
            '{OP_ADD,  16'h0002, 1'b0, isc_pkg::KIND_ADDED},
            '{OP_LIST, 16'hFFFF, 1'b0, isc_pkg::KIND_ADDED},
            '{OP_ADD,  16'hFFFF, 1'b1, isc_pkg::KIND_DUPLICATE},
            '{OP_ADD,  16'h5555, 1'b0, isc_pkg::KIND_ADDED},
            '{OP_ADD,  16'hAAAA, 1'b0, isc_pkg::KIND_ADDED},
            '{OP_ADD,  16'h7FFF, 1'b0, isc_pkg::KIND_ADDED},
            '{OP_ADD,  16'h8000, 1'b0, isc_pkg::KIND_ADDED},
            '{OP_ADD,  16'h8001, 1'b0, isc_pkg::KIND_ADDED},
            '{OP_ADD,  16'h7FFE, 1'b0, isc_pkg::KIND_ADDED},
            '{OP_ADD,  16'h0005, 1'b0, isc_pkg::KIND_ADDED},
            '{OP_ADD,  16'h0004, 1'b0, isc_pkg::KIND_ADDED},
            '{OP_ADD,  16'h5555, 1'b0, isc_pkg::KIND_ADDED},
            '{OP_LIST, 16'h1234, 1'b0, isc_pkg::KIND_ADDED}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[n]) begin
            idle_some(7);
            send_item(dir_rows[n].op, dir_rows[n].value, dir_rows[n].pinned, dir_rows[n].kind);
        end

        // Wide values fill the table past capacity; the small window keeps merging.
        for (int phase = 0; phase < 3; phase++) begin
            pct = (phase == 0) ? 7 : (phase == 1) ? 84 : 0;
            for (int n = 0; n < (RAND_ITEMS + 2) / 3; n++) begin
                r  = $urandom_range(0, 99);
                op = OP_ADD;
                if (r < 8) begin
                    op = OP_LIST;
                    v  = $urandom_range(0, 65535);
                end else if (r < 38) begin
                    v = $urandom_range(0, 63);
                end else if (r < 90) begin
                    v = $urandom_range(0, 65535);
                end else begin
                    case ($urandom_range(0, 3))
                        0: v = 16'h0000;
                        1: v = 16'h0001;
                        2: v = 16'hFFFE;
                        default: v = 16'hFFFF;
                    endcase
                end
                idle_some(pct);
                send_item(op, v, 1'b0, isc_pkg::KIND_ADDED);
            end
        end
        start <= 1'b0;

        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (2 * TABLE_DEPTH) @(posedge i_clk);

        $display("Sent %0d adds and %0d lists; %0d result beats checked.",
                 adds_sent, lists_sent, beats_checked);
        $display("Mix: %0d added, %0d duplicate, %0d dropped, %0d entries, %0d empty lists.",
                 kind_count[0], kind_count[1], kind_count[2], kind_count[3], kind_count[4]);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
sv/isc_pkg.sv
sv/isc_cell.sv
sv/interval_set_coalescer_unit.sv
tb/interval_set_coalescer_unit_test.sv
